// File: rtl/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round tables shared by the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned BufDepth = 16;
  localparam int unsigned BufAw    = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // message word index used by round i
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'(5 * i[3:0] + 1);
      2'd2:    g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

// File: rtl/md5_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: rtl/md5_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_message_digest
// Streaming MD5 engine: bytes pack into a 16x32 word RAM; a full block runs
// 64 rounds, one per cycle, reading the message word from that RAM.
// A byte beat that closes a block holds the input through RAM read setup, the
// 64 rounds and the fold; the next byte is not taken until the fold is done.
// Last beat: n pad-word writes (n = 16 - word position), then the block, and
// a second padded block when padding spills over; four digest beats follow.
// Input stalls until they are taken.
// Reset: chaining words set to the MD5 initial values, counts cleared.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  message_byte_i,
  input  logic        has_byte_i,
  input  logic        last_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);

  md5_pkg::state_e state_q, state_d;

  logic [31:0] ca_q, cb_q, cc_q, cd_q;
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  fill_q, fill_d;
  logic [31:0] blocks_q, blocks_d;
  logic [23:0] part_q, part_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [3:0]  padw_q, padw_d;
  logic        msg_end_q, msg_end_d;  // last beat taken, digest still due
  logic        len_blk_q, len_blk_d;  // block being padded carries the length
  logic        marked_q, marked_d;    // 0x80 already placed
  logic [1:0]  oidx_q, oidx_d;
  logic        chain_upd, chain_rst;
  logic [63:0] bits;

  logic                      ram_we;
  logic [md5_pkg::BufAw-1:0] ram_addr;
  logic [31:0]               ram_wdata, ram_rdata;

  md5_ram #(.Width(32), .Depth(md5_pkg::BufDepth)) u_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  logic        accept;
  logic [31:0] word_full, pad_word, f_val, sum, rot;
  logic [4:0]  sh;

  assign in_ready_o = (state_q == md5_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign bits       = {23'h0, blocks_q, fill_q, 3'b000};

  always_comb begin
    word_full = 32'h0;
    case (fill_q[1:0])
      2'd0:    word_full = {24'h0, message_byte_i};
      2'd1:    word_full = {16'h0, message_byte_i, part_q[7:0]};
      2'd2:    word_full = {8'h0, message_byte_i, part_q[15:0]};
      default: word_full = {message_byte_i, part_q};
    endcase
  end

  // padding word padw_q: 0x80 at fill, zeros after, length in words 14 and 15
  always_comb begin
    pad_word = 32'h0;
    if (!marked_q && padw_q == fill_q[5:2]) begin
      case (fill_q[1:0])
        2'd0:    pad_word = {24'h0, md5_pkg::PadByte};
        2'd1:    pad_word = {16'h0, md5_pkg::PadByte, part_q[7:0]};
        2'd2:    pad_word = {8'h0, md5_pkg::PadByte, part_q[15:0]};
        default: pad_word = {md5_pkg::PadByte, part_q};
      endcase
    end
    if (len_blk_q && padw_q == 4'd14) begin
      pad_word = bits[31:0];
    end else if (len_blk_q && padw_q == 4'd15) begin
      pad_word = bits[63:32];
    end
  end

  assign ram_wdata = (state_q == md5_pkg::ST_PAD) ? pad_word : word_full;

  always_comb begin
    case (rnd_q[5:4])
      2'd0:    f_val = d_q ^ (b_q & (c_q ^ d_q));
      2'd1:    f_val = c_q ^ (d_q & (b_q ^ c_q));
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    sh  = md5_pkg::round_s(rnd_q);
    sum = a_q + f_val + md5_pkg::round_k(rnd_q) + ram_rdata;
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      md5_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_byte_i && fill_q == 6'd63) begin
            state_d = md5_pkg::ST_LOAD;
          end else if (last_item_i) begin
            state_d = md5_pkg::ST_PAD;
          end
        end
      end
      md5_pkg::ST_PAD: begin
        if (padw_q == 4'd15) begin
          state_d = md5_pkg::ST_LOAD;
        end
      end
      md5_pkg::ST_LOAD: begin
        state_d = md5_pkg::ST_ROUND;
      end
      md5_pkg::ST_ROUND: begin
        if (rnd_q == 6'd63) begin
          state_d = md5_pkg::ST_FOLD;
        end
      end
      md5_pkg::ST_FOLD: begin
        if (!msg_end_q) begin
          state_d = md5_pkg::ST_IDLE;
        end else if (!len_blk_q) begin
          state_d = md5_pkg::ST_PAD;
        end else begin
          state_d = md5_pkg::ST_OUT;
        end
      end
      md5_pkg::ST_OUT: begin
        if (out_ready_i && oidx_q == 2'd3) begin
          state_d = md5_pkg::ST_IDLE;
        end
      end
      default: state_d = md5_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    fill_d    = fill_q;
    blocks_d  = blocks_q;
    part_d    = part_q;
    rnd_d     = rnd_q;
    padw_d    = padw_q;
    msg_end_d = msg_end_q;
    len_blk_d = len_blk_q;
    marked_d  = marked_q;
    oidx_d    = oidx_q;
    chain_upd = 1'b0;
    chain_rst = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = fill_q[5:2];
    case (state_q)
      md5_pkg::ST_IDLE: begin
        if (accept) begin
          if (has_byte_i) begin
            ram_we = (fill_q[1:0] == 2'd3);
            part_d = word_full[23:0];
            fill_d = fill_q + 6'd1;
          end
          msg_end_d = last_item_i;
          marked_d  = 1'b0;
          if (has_byte_i && fill_q == 6'd63) begin
            blocks_d  = blocks_q + 32'd1;
            len_blk_d = 1'b0;
          end else begin
            len_blk_d = (fill_d < 6'd56);
          end
          padw_d = fill_d[5:2];
        end
      end
      md5_pkg::ST_PAD: begin
        ram_we   = 1'b1;
        ram_addr = padw_q;
        padw_d   = padw_q + 4'd1;
        if (padw_q == fill_q[5:2]) begin
          marked_d = 1'b1;
        end
      end
      md5_pkg::ST_LOAD: begin
        ram_addr = md5_pkg::round_g(6'd0);
        rnd_d    = 6'd0;
      end
      md5_pkg::ST_ROUND: begin
        // word for round rnd_q was addressed last cycle
        ram_addr = md5_pkg::round_g(rnd_q + 6'd1);
        rnd_d    = rnd_q + 6'd1;
      end
      md5_pkg::ST_FOLD: begin
        chain_upd = 1'b1;
        padw_d    = 4'd0;
        len_blk_d = 1'b1;
        oidx_d    = 2'd0;
      end
      md5_pkg::ST_OUT: begin
        if (out_ready_i) begin
          oidx_d = oidx_q + 2'd1;
          if (oidx_q == 2'd3) begin
            chain_rst = 1'b1;
            fill_d    = 6'd0;
            blocks_d  = 32'd0;
            msg_end_d = 1'b0;
          end
        end
      end
      default: ram_we = 1'b0;
    endcase
  end

  assign out_valid_o   = (state_q == md5_pkg::ST_OUT);
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 2'd3);
  always_comb begin
    case (oidx_q)
      2'd0:    digest_word_o = ca_q;
      2'd1:    digest_word_o = cb_q;
      2'd2:    digest_word_o = cc_q;
      default: digest_word_o = cd_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= md5_pkg::ST_IDLE;
      fill_q    <= 6'd0;
      blocks_q  <= 32'd0;
      rnd_q     <= 6'd0;
      padw_q    <= 4'd0;
      msg_end_q <= 1'b0;
      len_blk_q <= 1'b0;
      marked_q  <= 1'b0;
      oidx_q    <= 2'd0;
      ca_q <= md5_pkg::InitA; cb_q <= md5_pkg::InitB;
      cc_q <= md5_pkg::InitC; cd_q <= md5_pkg::InitD;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      blocks_q  <= blocks_d;
      rnd_q     <= rnd_d;
      padw_q    <= padw_d;
      msg_end_q <= msg_end_d;
      len_blk_q <= len_blk_d;
      marked_q  <= marked_d;
      oidx_q    <= oidx_d;
      if (chain_rst) begin
        ca_q <= md5_pkg::InitA; cb_q <= md5_pkg::InitB;
        cc_q <= md5_pkg::InitC; cd_q <= md5_pkg::InitD;
      end else if (chain_upd) begin
        ca_q <= ca_q + a_q; cb_q <= cb_q + b_q;
        cc_q <= cc_q + c_q; cd_q <= cd_q + d_q;
      end
    end
  end

  // working registers and byte assembly
  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    if (state_q == md5_pkg::ST_ROUND) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= b_q + rot;
    end else begin
      a_q <= ca_q; b_q <= cb_q; c_q <= cc_q; d_q <= cd_q;
    end
  end

endmodule

// File: tb/md5_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// md5_digest_checker
// Watches the byte and digest channels of the MD5 engine. Every accepted byte
// beat feeds a behavioral MD5 (block buffer, chaining words, block count);
// a last beat pads, closes the message and queues the four digest words,
// which are compared field by field against the output beats.
// ----------------------------------------------------------------------------
module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  message_byte_i,
  input  logic        has_byte_i,
  input  logic        last_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [1:0]  word_index_i,
  input  logic        last_word_i,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] RoundK [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  localparam int RotAmt [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23,
                                 6, 10, 15, 21};

  logic [31:0]  chain [4];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [31:0]  nblocks;
  digest_beat_t digest_q [$];
  int unsigned  errs;

  assign err_count_o = errs;
  assign pending_o   = digest_q.size();

  function automatic logic [31:0] rol(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      m[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = d ^ (b & (c ^ d)); g = i;
      end else if (i < 32) begin
        f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = d; d = c; c = b;
      b = b + rol(a + f + RoundK[i] + m[g], RotAmt[((i / 16) * 4) + (i % 4)]);
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic restart();
    chain[0] = md5_pkg::InitA; chain[1] = md5_pkg::InitB;
    chain[2] = md5_pkg::InitC; chain[3] = md5_pkg::InitD;
    fill = 0;
    nblocks = '0;
  endtask

  task automatic absorb(logic [7:0] byte_v, logic has, logic fin);
    logic [63:0] bits;
    digest_beat_t e;
    if (has) begin
      blk[fill] = byte_v;
      fill++;
      if (fill == 64) begin
        compress();
        fill = 0;
        nblocks++;
      end
    end
    if (fin) begin
      bits = ((64'(nblocks) << 6) + 64'(fill)) << 3;
      blk[fill] = md5_pkg::PadByte;
      fill++;
      if (fill > 56) begin
        while (fill < 64) begin
          blk[fill] = 8'h00; fill++;
        end
        compress();
        fill = 0;
      end
      while (fill < 56) begin
        blk[fill] = 8'h00; fill++;
      end
      for (int k = 0; k < 8; k++) blk[56+k] = bits[8*k +: 8];
      compress();
      for (int k = 0; k < 4; k++) begin
        e.word = chain[k];
        e.idx  = 2'(k);
        e.last = (k == 3);
        digest_q.push_back(e);
      end
      restart();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    digest_beat_t exp_b;
    if (!rst_ni) begin
      restart();
      digest_q.delete();
      errs = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (digest_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t unexpected digest beat word=%h idx=%0d last=%0b",
                     $time, digest_word_i, word_index_i, last_word_i);
        end else begin
          exp_b = digest_q.pop_front();
          if (exp_b.word !== digest_word_i || exp_b.idx !== word_index_i ||
              exp_b.last !== last_word_i) begin
            errs++;
            if (errs <= 10)
              $display("%0t digest mismatch exp word=%h idx=%0d last=%0b got %h %0d %0b",
                       $time, exp_b.word, exp_b.idx, exp_b.last,
                       digest_word_i, word_index_i, last_word_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        absorb(message_byte_i, has_byte_i, last_item_i);
    end
  end

endmodule

// File: tb/tb_md5_message_digest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_md5_message_digest
// Drives byte beats into the MD5 engine: directed messages (empty, padding
// boundaries around 55/56/64 bytes, idle beats, extreme byte values) and
// random messages of mostly short lengths with a few multi-block ones, under
// random sender and receiver stalls, a long receiver hold-off and a drain.
// ----------------------------------------------------------------------------
module tb_md5_message_digest;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  message_byte;
  logic        has_byte;
  logic        last_item;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  int unsigned err_count;
  int unsigned pending;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          recv_hold;
  int          n_items;

  md5_message_digest u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .message_byte_i (message_byte),
    .has_byte_i     (has_byte),
    .last_item_i    (last_item),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .digest_word_o  (digest_word),
    .word_index_o   (word_index),
    .last_word_o    (last_word)
  );

  md5_digest_checker u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .message_byte_i (message_byte),
    .has_byte_i     (has_byte),
    .last_item_i    (last_item),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .digest_word_i  (digest_word),
    .word_index_i   (word_index),
    .last_word_i    (last_word),
    .err_count_o    (err_count),
    .pending_o      (pending)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(negedge clk) begin
    if (!rst_n || recv_hold)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one beat; valid held until accepted, dropped only by an idle or a drain
  task automatic send_beat(logic [7:0] b, logic has, logic fin);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    message_byte <= b;
    has_byte     <= has;
    last_item    <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_items++;
  endtask

  task automatic send_message(int len, int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       b = 8'($urandom);
        1:       b = 8'hff;
        2:       b = 8'h00;
        default: b = 8'(i);
      endcase
      if ($urandom_range(15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1) == 0) begin
        send_beat(b, 1'b1, 1'b1);
        return;
      end
      send_beat(b, 1'b1, 1'b0);
    end
    send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  initial begin
    int len;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    message_byte = 8'h00;
    has_byte     = 1'b0;
    last_item    = 1'b0;
    recv_hold    = 1'b0;
    n_items      = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hff, 1'b0, 1'b1);
    send_beat(8'hff, 1'b1, 1'b1);
    send_beat(8'h00, 1'b1, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_message(3, 3);
    send_message(5, 1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 28 : 0;
      if (phase == 0) begin
        send_message(55, 2);
        send_message(56, 1);
        send_message(64, 0);
      end
      if (phase == 1) begin
        fork
          begin
            recv_hold = 1'b1;
            repeat (600) @(negedge clk);
            recv_hold = 1'b0;
          end
          for (int m = 0; m < 6; m++) send_message($urandom_range(3), 0);
        join
        drain();
      end
      while (n_items < 120 * (phase + 1)) begin
        case ($urandom_range(9))
          0:       len = $urandom_range(130, 60);
          1:       len = $urandom_range(57, 54);
          default: len = $urandom_range(20);
        endcase
        send_message(len, ($urandom_range(7) == 0) ? 1 + $urandom_range(2) : 0);
      end
      drain();
    end

    if (err_count == 0)
      $display("PASS md5_message_digest");
    else
      $display("FAIL md5_message_digest");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL md5_message_digest");
    $finish;
  end

endmodule
